FILE: design/tww_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the timing wheel timer.
// No dependencies; used by tww_div and timing_wheel_timer.
package tww_pkg;

   localparam int WHEEL_SLOTS = 64;
   localparam int TIMER_POOL  = 32;
   localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
   localparam int IDX_W       = $clog2(TIMER_POOL);
   localparam int ROT_W       = 14;
   localparam int TIMEOUT_W   = 21;
   localparam int DIVIDEND_W  = TIMEOUT_W - 1;
   localparam int INTERVAL_W  = 8;
   localparam int ACTION_W    = 2;
   localparam int KIND_W      = 3;
   localparam int DIV_STEPS   = DIVIDEND_W;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_REJ   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_BAD   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

   typedef struct packed {
      logic start;
      logic step;
   } div_ctrl_type;

endpackage

FILE: design/tww_div.sv
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per step.
// Depends on tww_pkg.
module tww_div (
   input  logic                              clock,
   input  tww_pkg::div_ctrl_type             div_ctrl,
   input  logic [tww_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [tww_pkg::INTERVAL_W-1:0]    divisor,
   output logic [tww_pkg::DIVIDEND_W-1:0]    quotient
);
   import tww_pkg::*;

   logic [INTERVAL_W-1:0] rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [INTERVAL_W:0]   trial;

   // The dividend shifts out of the top of quo_ff while quotient bits enter at the bottom.
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (div_ctrl.start) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (div_ctrl.step) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = INTERVAL_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[INTERVAL_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

FILE: design/timing_wheel_timer.sv
`timescale 1ns / 1ps
// Timing wheel timer: top level with sequencer, entry pool and output register.
// Depends on tww_pkg and tww_div.
//
// A single-level wheel of 64 slots over a pool of 32 timer entries. An add
// with a valid timeout takes the accept cycle, then a pass in which the
// shared serial divider turns the timeout into ticks in 20 steps while the same
// counter walks the valid bits for the lowest free entry, then delivers its
// item. A delete takes the accept cycle, then delivers its item. A tick takes
// the accept cycle, walks all 32 entries one per cycle, and also waits on every
// expired item that meets a full output register, then delivers its done item.
// The final item of any request also waits while the output register is full.
// The input is not ready while an item is in work.
// The tick interval register may be written only while the block is idle.
module timing_wheel_timer (
   input  logic        clock,
   input  logic        reset,
   // req_tdata fields, low bit up: action[1:0], timeout[22:2], handle[27:23], zero fill.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // rsp_tdata fields: timer_id[4:0], zero fill.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // rsp_tuser fields: kind[2:0].
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import tww_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADD  = 2'd1;
   localparam logic [1:0] S_TICK = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(TIMER_POOL - 1);
   localparam logic [IDX_W-1:0]      DIV_LAST = IDX_W'(DIV_STEPS);
   localparam logic [DIVIDEND_W-1:0] ROT_MAX  = DIVIDEND_W'((1 << ROT_W) - 1);

   logic [ACTION_W-1:0]   req_action;
   logic [TIMEOUT_W-1:0]  req_timeout;
   logic [IDX_W-1:0]      req_handle;

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [KIND_W-1:0]     res_kind_ff, res_kind_in;
   logic [IDX_W-1:0]      res_id_ff, res_id_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic [TIMER_POOL-1:0] valid_ff, valid_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;

   logic [SLOT_W-1:0]     slot_mem_ff [TIMER_POOL];
   logic [ROT_W-1:0]      rot_mem_ff  [TIMER_POOL];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  out_free;
   logic                  out_load;
   logic [KIND_W-1:0]     out_kind;
   logic [IDX_W-1:0]      out_id;
   logic                  out_last;

   div_ctrl_type          div_ctrl;
   logic [INTERVAL_W-1:0] divisor;
   logic [DIVIDEND_W-1:0] quotient;
   logic [DIVIDEND_W-1:0] ticks;
   logic [DIVIDEND_W-1:0] rot_full;
   logic [ROT_W-1:0]      rot_new;
   logic [SLOT_W-1:0]     slot_new;

   logic                  ent_wr;
   logic                  rot_wr;
   logic [ROT_W-1:0]      rot_wdata;
   logic [IDX_W-1:0]      ent_idx;
   logic                  hit;
   logic                  advance;
   logic                  found_now;
   logic [IDX_W-1:0]      idx_now;

   assign req_action  = req_tdata[1:0];
   assign req_timeout = req_tdata[22:2];
   assign req_handle  = req_tdata[27:23];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // A zero interval behaves as one.
   assign divisor = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;

   tww_div u_div (
      .clock    (clock),
      .div_ctrl (div_ctrl),
      .dividend (req_timeout[DIVIDEND_W-1:0]),
      .divisor  (divisor),
      .quotient (quotient)
   );

   // A timeout below the interval gives a quotient of zero, which counts as one tick.
   assign ticks    = (quotient == '0) ? DIVIDEND_W'(1) : quotient;
   assign rot_full = ticks >> SLOT_W;
   assign rot_new  = (rot_full > ROT_MAX) ? ROT_MAX[ROT_W-1:0] : rot_full[ROT_W-1:0];
   assign slot_new = cur_slot_ff + ticks[SLOT_W-1:0];

   assign hit       = valid_ff[cnt_ff] && (slot_mem_ff[cnt_ff] == cur_slot_ff);
   assign found_now = found_ff || !valid_ff[cnt_ff];
   assign idx_now   = found_ff ? free_idx_ff : cnt_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      found_in    = found_ff;
      free_idx_in = free_idx_ff;
      res_kind_in = res_kind_ff;
      res_id_in   = res_id_ff;
      cur_slot_in = cur_slot_ff;
      valid_in    = valid_ff;
      out_load    = 1'b0;
      out_kind    = KIND_TICK_DONE;
      out_id      = '0;
      out_last    = 1'b0;
      div_ctrl    = '0;
      ent_wr      = 1'b0;
      rot_wr      = 1'b0;
      rot_wdata   = rot_new;
      ent_idx     = cnt_ff;
      advance     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_ADD: begin
                     if (req_timeout[TIMEOUT_W-1]) begin
                        res_kind_in = KIND_ADD_REJ;
                        res_id_in   = '0;
                        state_in    = S_RESP;
                     end else begin
                        div_ctrl.start = 1'b1;
                        cnt_in         = '0;
                        found_in       = 1'b0;
                        state_in       = S_ADD;
                     end
                  end
                  ACT_DELETE: begin
                     res_id_in = req_handle;
                     if (valid_ff[req_handle]) begin
                        valid_in[req_handle] = 1'b0;
                        res_kind_in          = KIND_DELETED;
                     end else begin
                        res_kind_in = KIND_DEL_BAD;
                     end
                     state_in = S_RESP;
                  end
                  ACT_TICK: begin
                     cnt_in   = '0;
                     state_in = S_TICK;
                  end
                  default: begin
                     res_kind_in = KIND_TICK_DONE;
                     res_id_in   = '0;
                     state_in    = S_RESP;
                  end
               endcase
            end
         end
         S_ADD: begin
            div_ctrl.step = (cnt_ff < DIV_LAST);
            if (!found_ff && !valid_ff[cnt_ff]) begin
               found_in    = 1'b1;
               free_idx_in = cnt_ff;
            end
            if (cnt_ff == LAST_IDX) begin
               if (found_now) begin
                  ent_wr            = 1'b1;
                  ent_idx           = idx_now;
                  valid_in[idx_now] = 1'b1;
                  res_kind_in       = KIND_ADDED;
                  res_id_in         = idx_now;
               end else begin
                  res_kind_in = KIND_ADD_REJ;
                  res_id_in   = '0;
               end
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         S_TICK: begin
            if (hit && (rot_mem_ff[cnt_ff] != '0)) begin
               rot_wr    = 1'b1;
               rot_wdata = rot_mem_ff[cnt_ff] - ROT_W'(1);
               advance   = 1'b1;
            end else if (hit) begin
               // An expiring entry holds the scan until the output register can take it.
               if (out_free) begin
                  out_load         = 1'b1;
                  out_kind         = KIND_EXPIRED;
                  out_id           = cnt_ff;
                  valid_in[cnt_ff] = 1'b0;
                  advance          = 1'b1;
               end
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               if (cnt_ff == LAST_IDX) begin
                  res_kind_in = KIND_TICK_DONE;
                  res_id_in   = '0;
                  cur_slot_in = cur_slot_ff + SLOT_W'(1);
                  state_in    = S_RESP;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_load = 1'b1;
               out_kind = res_kind_ff;
               out_id   = res_id_ff;
               out_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = out_kind;
         rsp_id_in    = out_id;
         rsp_last_in  = out_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign interval_in = csr_we ? csr_wdata : interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         cur_slot_ff  <= '0;
         valid_ff     <= '0;
         interval_ff  <= INTERVAL_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         cur_slot_ff  <= cur_slot_in;
         valid_ff     <= valid_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      res_kind_ff <= res_kind_in;
      res_id_ff   <= res_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (ent_wr) begin
         slot_mem_ff[ent_idx] <= slot_new;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_wr || rot_wr) begin
         rot_mem_ff[ent_idx] <= rot_wdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - IDX_W){1'b0}}, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An add with a valid timeout always starts the divider sequence.
   a_add_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_ADD) && !req_timeout[TIMEOUT_W-1])
      |=> (state_ff == S_ADD))
      else $error("add item did not start the divider sequence");

   // Expired items are never the final item of a tick.
   a_expired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_EXPIRED)) |-> !rsp_tlast)
      else $error("expired item marked as last");

   // The wheel only turns at the end of a tick scan.
   a_slot_moves_on_tick: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(cur_slot_ff))
      |-> (($past(state_ff) == S_TICK) && (state_ff == S_RESP)))
      else $error("current slot changed outside a tick");

endmodule
